[rtl/core/integer_matrix_multiply_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the integer matrix multiplier
// Concurrent checks that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef INTEGER_MATRIX_MULTIPLY_ASSERT_SVH
`define INTEGER_MATRIX_MULTIPLY_ASSERT_SVH

`ifndef SYNTHESIS
// property that holds on every clock edge out of reset
`define IMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent in one cycle implies consequent in the next
`define IMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IMM_ASSERT(lbl, prop, msg)
`define IMM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/core/imm_pkg.sv]
// ----------------------------------------------------------------------------
// imm_pkg
// Types, widths and constants shared by the matrix multiplier modules.
// ----------------------------------------------------------------------------
package imm_pkg;

  localparam int unsigned ELEM_W  = 16;  // matrix element
  localparam int unsigned PROD_W  = 32;  // product element
  localparam int unsigned IDX_W   = 3;   // row / column index
  localparam int unsigned DIMV_W  = 4;   // dimension register
  localparam int unsigned CNT_W   = 8;   // load counter
  localparam int unsigned RECIP_W = 17;  // reciprocal table entry
  localparam int unsigned CFG_AW  = 2;   // register index
  localparam int unsigned QDEPTH  = 4;   // result queue entries
  localparam int unsigned QPTR_W  = 2;
  localparam int unsigned QCNT_W  = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_COMPUTE
  } imm_state_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2
  } imm_reg_t;

  // control that travels with each store read through the MAC pipeline
  typedef struct packed {
    logic             vld;
    logic             first;  // first term of a dot product
    logic             lastk;  // last term of a dot product
    logic             last;   // dot product is the final product element
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } imm_tag_t;

  typedef struct packed {
    logic             vld;
    logic             last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } imm_res_t;

  // ceil(2^16 / w): (idx * recip(w)) >> 16 equals idx / w for idx < 256, w <= 8
  function automatic logic [RECIP_W-1:0] recip(input logic [DIMV_W-1:0] w);
    logic [RECIP_W-1:0] r;
    case (w)
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/imm_ram.sv]
// ----------------------------------------------------------------------------
// imm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module imm_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/imm_mac.sv]
// ----------------------------------------------------------------------------
// imm_mac
// Multiply-accumulate pipeline: store data in, one dot product per result out.
// ----------------------------------------------------------------------------
module imm_mac import imm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  imm_tag_t                 issue_tag,
  input  logic signed [ELEM_W-1:0] a_rdata,
  input  logic signed [ELEM_W-1:0] b_rdata,
  output imm_res_t                 res,
  output logic [PROD_W-1:0]        res_value
);

  imm_tag_t                 s1_r;
  imm_tag_t                 s2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0]        acc_r;
  logic [PROD_W-1:0]        acc_nxt;

  // s1 lines up with the RAM read data, s2 with the product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else begin
      s1_r <= issue_tag;
      s2_r <= s1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a_rdata * b_rdata;
    if (s2_r.vld) begin
      acc_r <= acc_nxt;
    end
  end

  // sum wraps in 32 bits
  assign acc_nxt = (s2_r.first ? '0 : acc_r) + PROD_W'(unsigned'(prod_r));

  assign res.vld   = s2_r.vld & s2_r.lastk;
  assign res.last  = s2_r.last;
  assign res.row   = s2_r.row;
  assign res.col   = s2_r.col;
  assign res_value = acc_nxt;

endmodule

[rtl/core/integer_matrix_multiply.sv]
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// Signed integer matrix product C = A * B with elements streamed in one by one.
// ----------------------------------------------------------------------------
// Usage: set rows_a (n), inner_dim (m) and cols_b (p) through the cfg port;
// 0 acts as 1 and values above MAX_DIM act as MAX_DIM. Then stream n*m
// elements of A and m*p elements of B, row-major, on the in_ channel.
// Each item is accepted in ST_IDLE and written in ST_LOAD before the next is
// taken: the accept cycle finds the row with a reciprocal multiply, the next
// works out the column and writes the element RAM. The item that completes B
// starts the product in ST_COMPUTE: one multiply-accumulate per cycle while
// the result queue has room, n*p*m store reads, each result valid on out_
// after the read, product and queue registers. in_tready stays low until the
// last read is issued. C leaves row-major on out_, tlast on the final element.
// A 4-entry result queue parts the MAC pipeline from the
// receiver; when the receiver stalls and 4 results are outstanding, reads
// pause at the start of the next dot product. The next pair may load
// while the last results still drain.
// Reset (rst_n low, synchronous) sets the dimensions to 1, clears the
// load counter and empties the queue; the RAMs are not cleared.
// ----------------------------------------------------------------------------
`include "integer_matrix_multiply_assert.svh"

module integer_matrix_multiply import imm_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // [15:0] elem_value
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata,  // [2:0] out_row, [5:3] out_col, [37:6] prod_value
  output logic              out_tlast,  // is_last
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [DIMV_W-1:0] cfg_wdata
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [DIMV_W-1:0] MAX_DIM_V = DIMV_W'(MAX_DIM);
  localparam logic [CNT_W-1:0]  MAX_ROW_V = CNT_W'(MAX_DIM);

  function automatic logic [DIMV_W-1:0] eff_dim(input logic [DIMV_W-1:0] v);
    logic [DIMV_W-1:0] d;
    if (v == '0) begin
      d = DIMV_W'(1);
    end else if (v > MAX_DIM_V) begin
      d = MAX_DIM_V;
    end else begin
      d = v;
    end
    return d;
  endfunction

  // configuration registers
  logic [DIMV_W-1:0] rows_a_r, inner_dim_r, cols_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIMV_W'(1);
      inner_dim_r <= DIMV_W'(1);
      cols_b_r    <= DIMV_W'(1);
    end else if (cfg_we) begin
      case (imm_reg_t'(cfg_addr))
        REG_ROWS_A:    rows_a_r    <= cfg_wdata;
        REG_INNER_DIM: inner_dim_r <= cfg_wdata;
        REG_COLS_B:    cols_b_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- load path ----------------
  imm_state_t state_r, state_nxt;
  logic [CNT_W-1:0] load_cnt_r;
  logic             in_acc;

  logic [DIMV_W-1:0]        dim_n, dim_m, dim_p, dim_w;
  logic [CNT_W-1:0]         a_total, total, ld_idx;
  logic                     ld_in_a, ld_trig;
  logic [CNT_W+RECIP_W-1:0] qprod;

  assign in_acc = in_tvalid & in_tready;

  assign dim_n   = eff_dim(rows_a_r);
  assign dim_m   = eff_dim(inner_dim_r);
  assign dim_p   = eff_dim(cols_b_r);
  assign a_total = CNT_W'(dim_n) * CNT_W'(dim_m);
  assign total   = a_total + CNT_W'(dim_m) * CNT_W'(dim_p);
  assign ld_in_a = load_cnt_r < a_total;
  assign ld_idx  = ld_in_a ? load_cnt_r : load_cnt_r - a_total;
  assign dim_w   = ld_in_a ? dim_m : dim_p;
  assign qprod   = (CNT_W+RECIP_W)'(ld_idx) * (CNT_W+RECIP_W)'(recip(dim_w));
  assign ld_trig = ({1'b0, load_cnt_r} + (CNT_W+1)'(1)) >= {1'b0, total};

  logic [CNT_W-1:0]  idx_r, quot_r;
  logic [DIMV_W-1:0] w_r, n_r, m_r, p_r;
  logic [ELEM_W-1:0] val_r;
  logic              sel_a_r, trig_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
      trig_r     <= 1'b0;
    end else if (in_acc) begin
      load_cnt_r <= ld_trig ? '0 : load_cnt_r + CNT_W'(1);
      trig_r     <= ld_trig;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      idx_r   <= ld_idx;
      quot_r  <= qprod[RECIP_W-1 +: CNT_W];
      w_r     <= dim_w;
      sel_a_r <= ld_in_a;
      val_r   <= in_tdata;
      n_r     <= dim_n;
      m_r     <= dim_m;
      p_r     <= dim_p;
    end
  end

  // element place: row = quot, column = remainder
  logic [CNT_W+DIMV_W-1:0] qw;
  logic [CNT_W-1:0]        ld_rem, ld_pos;
  logic                    ld_drop, wr_a, wr_b;
  logic [AW-1:0]           waddr;

  assign qw      = (CNT_W+DIMV_W)'(quot_r) * (CNT_W+DIMV_W)'(w_r);
  assign ld_rem  = idx_r - qw[CNT_W-1:0];
  assign ld_drop = quot_r >= MAX_ROW_V;
  assign ld_pos  = CNT_W'(quot_r[IDX_W-1:0]) * MAX_ROW_V + CNT_W'(ld_rem[IDX_W-1:0]);
  assign waddr   = ld_pos[AW-1:0];
  assign wr_a    = (state_r == ST_LOAD) & ~ld_drop & sel_a_r;
  assign wr_b    = (state_r == ST_LOAD) & ~ld_drop & ~sel_a_r;

  // ---------------- compute sequencer ----------------
  logic [IDX_W-1:0]  i_r, j_r, k_r, i_nxt, j_nxt, k_nxt;
  logic [QCNT_W-1:0] pend_cnt_r, q_cnt_r;
  logic              k_last, j_last, i_last, issue_go, q_pop;
  imm_tag_t          issue_tag;
  logic [CNT_W-1:0]  ra_pos, rb_pos;

  assign k_last   = (DIMV_W'(k_r) + DIMV_W'(1)) == m_r;
  assign j_last   = (DIMV_W'(j_r) + DIMV_W'(1)) == p_r;
  assign i_last   = (DIMV_W'(i_r) + DIMV_W'(1)) == n_r;
  // reserve a queue slot before the first term of each dot product
  assign issue_go = (state_r == ST_COMPUTE) &
                    ((k_r != '0) | (pend_cnt_r < QCNT_W'(QDEPTH)));

  assign issue_tag.vld   = issue_go;
  assign issue_tag.first = k_r == '0;
  assign issue_tag.lastk = k_last;
  assign issue_tag.last  = i_last & j_last;
  assign issue_tag.row   = i_r;
  assign issue_tag.col   = j_r;

  assign ra_pos = CNT_W'(i_r) * MAX_ROW_V + CNT_W'(k_r);
  assign rb_pos = CNT_W'(k_r) * MAX_ROW_V + CNT_W'(j_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        i_nxt = '0;
        j_nxt = '0;
        k_nxt = '0;
        state_nxt = trig_r ? ST_COMPUTE : ST_IDLE;
      end
      ST_COMPUTE: begin
        if (issue_go) begin
          if (!k_last) begin
            k_nxt = k_r + IDX_W'(1);
          end else begin
            k_nxt = '0;
            if (!j_last) begin
              j_nxt = j_r + IDX_W'(1);
            end else begin
              j_nxt = '0;
              i_nxt = i_r + IDX_W'(1);
              if (i_last) begin
                state_nxt = ST_IDLE;
              end
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- stores and MAC ----------------
  logic signed [ELEM_W-1:0] a_rdata, b_rdata;
  imm_res_t                 res;
  logic [PROD_W-1:0]        res_value;

  imm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_store (
    .clk   (clk),
    .we    (wr_a),
    .waddr (waddr),
    .wdata (val_r),
    .raddr (ra_pos[AW-1:0]),
    .rdata (a_rdata)
  );

  imm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_b_store (
    .clk   (clk),
    .we    (wr_b),
    .waddr (waddr),
    .wdata (val_r),
    .raddr (rb_pos[AW-1:0]),
    .rdata (b_rdata)
  );

  imm_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue_tag (issue_tag),
    .a_rdata   (a_rdata),
    .b_rdata   (b_rdata),
    .res       (res),
    .res_value (res_value)
  );

  // ---------------- result queue ----------------
  logic [IDX_W-1:0]  q_row  [QDEPTH];
  logic [IDX_W-1:0]  q_col  [QDEPTH];
  logic              q_last [QDEPTH];
  logic [PROD_W-1:0] q_val  [QDEPTH];
  logic [QPTR_W-1:0] q_wp_r, q_rp_r;

  assign q_pop = out_tvalid & out_tready;

  always_ff @(posedge clk) begin
    if (res.vld) begin
      q_row[q_wp_r]  <= res.row;
      q_col[q_wp_r]  <= res.col;
      q_last[q_wp_r] <= res.last;
      q_val[q_wp_r]  <= res_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r     <= '0;
      q_rp_r     <= '0;
      q_cnt_r    <= '0;
      pend_cnt_r <= '0;
    end else begin
      if (res.vld) begin
        q_wp_r <= q_wp_r + QPTR_W'(1);
      end
      if (q_pop) begin
        q_rp_r <= q_rp_r + QPTR_W'(1);
      end
      q_cnt_r    <= q_cnt_r + QCNT_W'(res.vld) - QCNT_W'(q_pop);
      pend_cnt_r <= pend_cnt_r + QCNT_W'(issue_go & issue_tag.first) - QCNT_W'(q_pop);
    end
  end

  assign out_tvalid = q_cnt_r != '0;
  assign out_tdata  = {2'b00, q_val[q_rp_r], q_col[q_rp_r], q_row[q_rp_r]};
  assign out_tlast  = q_last[q_rp_r];

  // ---------------- checks ----------------
  `IMM_ASSERT(a_pend_bound, pend_cnt_r <= QCNT_W'(QDEPTH), "result reservations exceed queue")
  `IMM_ASSERT(a_push_room, res.vld |-> (q_cnt_r < QCNT_W'(QDEPTH)), "push into full queue")
  `IMM_ASSERT(a_pend_cover, q_cnt_r <= pend_cnt_r, "queued result without reservation")
  `IMM_ASSERT_NEXT(a_trig_compute, (state_r == ST_LOAD) && trig_r, state_r == ST_COMPUTE,
                   "completed pair did not start the product")

endmodule
